/* sv/slt_pkg.sv */
// package for the sorted list table: sizes, operation and status codes
package slt_pkg;
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 5;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;
	localparam logic [1:0] FN_CLEAR  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
endpackage

/* sv/sorted_list_table.sv */
// sorted list table: ascending list of signed words kept in a memory with one write and one read port
//
// start/busy command port: a word (func, value, index) is taken at an edge where
// start is high and busy is low. busy stays high while the operation runs.
// done marks the one cycle in which status, read_value, count, is_empty and
// is_full are valid; the receiver cannot stall, so it must take them then.
// one memory write port, one registered read port and one signed compare are
// shared by every step, so an operation handles the entries it touches in turn:
//   clear, and any rejected operation: settled in the start step itself
//   read: the entry at index is read, then given out
//   insert: each entry larger than the value is read and shifted up one
//           place, from the end down, then the value is written into the gap
//   remove: entries are compared from position 0 up to the first equal one;
//           on a hit each later one shifts down a place, else not found
// done rises in the cycle after the final step; a new start may be given in the
// done cycle itself. reset empties the list (count zero); memory contents are
// not cleared and are only used at positions below the count.
module sorted_list_table import slt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic signed [DATA_W-1:0] value,
	input  logic [IDX_W-1:0]         index,
	output logic                     done,
	output logic [2:0]               status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count,
	output logic                     is_empty,
	output logic                     is_full
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_RD  = 4'd1;
	localparam logic [3:0] S_INS_CMP = 4'd2;
	localparam logic [3:0] S_RM_RD   = 4'd3;
	localparam logic [3:0] S_RM_CMP  = 4'd4;
	localparam logic [3:0] S_SH_RD   = 4'd5;
	localparam logic [3:0] S_SH_WR   = 4'd6;
	localparam logic [3:0] S_RD_OUT  = 4'd7;

	logic [3:0]               state_q, state_d;
	logic [CNT_W-1:0]         pos_q, pos_d, pos_m1, pos_p1;
	logic [CNT_W-1:0]         count_q, count_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	logic                     done_q, fin;
	logic [2:0]               status_q, st_d;
	logic signed [DATA_W-1:0] rv_q, rv_d;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rdata_q;
	logic                     we;
	logic [ADDR_W-1:0]        waddr, raddr;
	logic signed [DATA_W-1:0] wdata;

	assign pos_m1 = pos_q - CNT_W'(1);
	assign pos_p1 = pos_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		count_d = count_q;
		val_d   = val_q;
		we      = 1'b0;
		waddr   = pos_q[ADDR_W-1:0];
		wdata   = val_q;
		raddr   = pos_m1[ADDR_W-1:0];
		fin     = 1'b0;
		st_d    = ST_OK;
		rv_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				raddr = ADDR_W'(index);
				if (start) begin
					val_d = value;
					unique case (func)
						FN_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								fin  = 1'b1;
								st_d = ST_FULL;
							end else begin
								pos_d   = count_q;
								state_d = S_INS_RD;
							end
						end
						FN_REMOVE: begin
							if (count_q == '0) begin
								fin  = 1'b1;
								st_d = ST_EMPTY;
							end else begin
								pos_d   = '0;
								state_d = S_RM_RD;
							end
						end
						FN_READ: begin
							if (CNT_W'(index) >= count_q) begin
								fin  = 1'b1;
								st_d = ST_RANGE;
							end else begin
								state_d = S_RD_OUT;
							end
						end
						FN_CLEAR: begin
							count_d = '0;
							fin     = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_INS_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					count_d = count_q + CNT_W'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (rdata_q > val_q) begin
					wdata   = rdata_q;
					pos_d   = pos_m1;
					state_d = S_INS_RD;
				end else begin
					count_d = count_q + CNT_W'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RM_RD: begin
				raddr   = pos_q[ADDR_W-1:0];
				state_d = S_RM_CMP;
			end
			S_RM_CMP: begin
				if (rdata_q == val_q) begin
					state_d = S_SH_RD;
				end else if (pos_p1 == count_q) begin
					fin     = 1'b1;
					st_d    = ST_NOT_FOUND;
					state_d = S_IDLE;
				end else begin
					pos_d   = pos_p1;
					state_d = S_RM_RD;
				end
			end
			S_SH_RD: begin
				raddr = pos_p1[ADDR_W-1:0];
				if (pos_p1 < count_q) begin
					state_d = S_SH_WR;
				end else begin
					count_d = count_q - CNT_W'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SH_WR: begin
				we      = 1'b1;
				wdata   = rdata_q;
				pos_d   = pos_p1;
				state_d = S_SH_RD;
			end
			S_RD_OUT: begin
				rv_d    = rdata_q;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		if (fin) begin
			status_q <= st_d;
			rv_q     <= rv_d;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rv_q;
	assign count      = count_q;
	assign is_empty   = (count_q == '0);
	assign is_full    = (count_q == CNT_W'(CAPACITY));

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FN_CLEAR |=> done && count == '0 && status == ST_OK)
		else $error("clear did not empty the list");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> is_full)
		else $error("full status with room left");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SH_WR |-> pos_p1 < count_q)
		else $error("shift past the end of the list");

endmodule

/* test/tb_sorted_list_table.sv */
// testbench for sorted_list_table: random and directed words checked against a list copy
module tb_sorted_list_table;
	import slt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
		logic                     is_full;
	} list_reply_t;

	class sorted_list_mirror;
		logic signed [DATA_W-1:0] store [CAPACITY];
		int unsigned              fill;
		list_reply_t              pending_replies [$];
		int                       mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void note_word(logic [1:0] fn, logic signed [DATA_W-1:0] v,
				logic [IDX_W-1:0] idx);
			list_reply_t r;
			int unsigned pos;
			int unsigned hit;
			r.status = ST_OK;
			r.read_value = '0;
			case (fn)
				FN_INSERT: begin
					if (fill >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						pos = fill;
						while (pos > 0 && store[pos-1] > v) begin
							store[pos] = store[pos-1];
							pos--;
						end
						store[pos] = v;
						fill++;
					end
				end
				FN_REMOVE: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						hit = fill;
						for (int i = fill - 1; i >= 0; i--)
							if (store[i] == v) hit = i;
						if (hit == fill) begin
							r.status = ST_NOT_FOUND;
						end else begin
							for (int unsigned i = hit; i + 1 < fill; i++)
								store[i] = store[i+1];
							fill--;
						end
					end
				end
				FN_READ: begin
					if (idx >= fill)
						r.status = ST_RANGE;
					else
						r.read_value = store[idx];
				end
				default: begin
					fill = 0;
				end
			endcase
			r.count = CNT_W'(fill);
			r.is_empty = (fill == 0);
			r.is_full = (fill == CAPACITY);
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [DATA_W+1:0] want,
				logic signed [DATA_W+1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_reply(logic [2:0] st, logic signed [DATA_W-1:0] rv,
				logic [CNT_W-1:0] cnt, logic emp, logic ful);
			list_reply_t w;
			if (pending_replies.size() == 0) begin
				$error("result word with no command pending");
				mismatches++;
				return;
			end
			w = pending_replies.pop_front();
			compare_field("status", w.status, st);
			compare_field("read_value", w.read_value, rv);
			compare_field("count", w.count, cnt);
			compare_field("is_empty", w.is_empty, emp);
			compare_field("is_full", w.is_full, ful);
		endfunction

		function logic signed [DATA_W-1:0] pick_present();
			if (fill == 0)
				return $urandom;
			return store[$urandom_range(fill - 1, 0)];
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               func = FN_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic [IDX_W-1:0]         index = '0;
	logic                     done;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         count;
	logic                     is_empty;
	logic                     is_full;

	sorted_list_mirror mirror = new();

	sorted_list_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.value      (value),
		.index      (index),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				mirror.note_word(func, value, index);
			if (done)
				mirror.check_reply(status, read_value, count, is_empty, is_full);
		end
	end

	// start stays high across back-to-back words
	task automatic send_word(logic [1:0] fn, logic signed [DATA_W-1:0] v,
			logic [IDX_W-1:0] idx, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func  <= fn;
		value <= v;
		index <= idx;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $signed($urandom_range(0, 6)) - 3;
			4: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh8000_0001;
					3: return 32'sh7fff_fffe;
					4: return -1;
					default: return 0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] draw_index();
		if (mirror.fill > 0 && $urandom_range(0, 99) < 80)
			return IDX_W'($urandom_range(mirror.fill - 1, 0));
		return IDX_W'($urandom_range(CAPACITY - 1, 0));
	endfunction

	initial begin
		int sent;
		int kind;
		int len;
		int r;
		bit no_gap;
		int gap;
		logic [1:0] fn;
		logic signed [DATA_W-1:0] v;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_word(FN_READ, 0, 0, $urandom_range(0, 6));
		send_word(FN_REMOVE, 5, 31, $urandom_range(0, 6));
		send_word(FN_CLEAR, -1, 31, $urandom_range(0, 6));
		// extremes and equal values
		send_word(FN_INSERT, 32'sh7fff_ffff, 0, $urandom_range(0, 6));
		send_word(FN_INSERT, 32'sh8000_0000, 0, $urandom_range(0, 6));
		send_word(FN_INSERT, 0, 0, $urandom_range(0, 6));
		send_word(FN_INSERT, -1, 0, $urandom_range(0, 6));
		send_word(FN_INSERT, 0, 0, $urandom_range(0, 6));
		for (int i = 0; i < 5; i++)
			send_word(FN_READ, 0, IDX_W'(i), $urandom_range(0, 6));
		send_word(FN_READ, 0, 5, $urandom_range(0, 6));
		send_word(FN_READ, 0, 31, $urandom_range(0, 6));
		send_word(FN_REMOVE, 7, 0, $urandom_range(0, 6));
		send_word(FN_REMOVE, 0, 0, $urandom_range(0, 6));
		send_word(FN_REMOVE, 32'sh8000_0000, 0, $urandom_range(0, 6));
		send_word(FN_REMOVE, 32'sh7fff_ffff, 0, $urandom_range(0, 6));
		send_word(FN_READ, 0, 1, $urandom_range(0, 6));
		send_word(FN_CLEAR, 0, 0, $urandom_range(0, 6));
		send_word(FN_READ, 0, 0, $urandom_range(0, 6));

		sent = 0;
		while (sent < 1700) begin
			kind = $urandom_range(0, 3);
			len = $urandom_range(10, 80);
			no_gap = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				v = draw_value();
				case (kind)
					0: begin
						if (r < 70) fn = FN_INSERT;
						else if (r < 85) fn = FN_READ;
						else fn = FN_REMOVE;
						if (fn == FN_REMOVE && r < 95) v = mirror.pick_present();
					end
					1: begin
						if (r < 70) fn = FN_REMOVE;
						else if (r < 85) fn = FN_READ;
						else if (r < 98) fn = FN_INSERT;
						else fn = FN_CLEAR;
						if (r < 55) v = mirror.pick_present();
					end
					2: begin
						if (r < 50) fn = FN_READ;
						else if (r < 75) fn = FN_INSERT;
						else if (r < 97) fn = FN_REMOVE;
						else fn = FN_CLEAR;
						if (fn == FN_REMOVE && r < 92) v = mirror.pick_present();
					end
					default: begin
						fn = 2'($urandom_range(0, 3));
						v = $urandom;
					end
				endcase
				gap = no_gap ? 0 : $urandom_range(0, 6);
				send_word(fn, v,
					(fn == FN_READ) ? draw_index() : IDX_W'($urandom_range(31, 0)), gap);
				sent++;
			end
		end
		start <= 1'b0;

		while (mirror.pending_replies.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#8ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
